FILE: design/gtg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Go-to-goal controller package
// Shared constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package gtg_pkg;

    localparam int CordicStepsDefault = 16;
    localparam int CordicStepsMax     = 24;
    localparam int VecW               = 40;
    localparam int AngW               = 28;

    localparam logic [1:0] CfgGoalX = 2'd0;
    localparam logic [1:0] CfgGoalY = 2'd1;

    localparam logic signed [AngW-1:0] HalfPiQ24 = 28'sd26353589;
    localparam logic signed [17:0] PiQ13    = 18'sd25736;
    localparam logic signed [17:0] TwoPiQ13 = 18'sd51472;
    localparam logic [33:0] TolQ16      = 34'd3277;
    localparam logic [33:0] VmaxQ16     = 34'd14418;
    localparam logic signed [21:0] WmaxQ16 = 22'sd65536;
    localparam logic signed [17:0] ErrSlowQ13 = 18'sd4096;
    localparam logic [15:0] SlowQ16     = 16'd13107;
    localparam logic [14:0] InvGainQ15  = 15'd19898;

    function automatic logic signed [AngW-1:0] atan_q24(input logic [4:0] idx);
        logic signed [AngW-1:0] v;
        unique case (idx)
            5'd0:  v = 28'sd13176795;
            5'd1:  v = 28'sd7778716;
            5'd2:  v = 28'sd4110060;
            5'd3:  v = 28'sd2086331;
            5'd4:  v = 28'sd1047214;
            5'd5:  v = 28'sd524117;
            5'd6:  v = 28'sd262123;
            5'd7:  v = 28'sd131069;
            default: v = (idx < 5'd24) ? (28'sd65536 >>> (idx - 5'd8)) : 28'sd0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/go_to_goal_drive_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Go-to-goal drive controller core
// Proportional steering toward a goal point from odometry words.
// ----------------------------------------------------------------------------
// Writing either goal register arms the block. Each odometry word accepted
// while armed produces exactly one speed word; while disarmed, words are
// consumed with no result. The speed word follows its odometry word through
// two passes of the shared CORDIC unit, one for yaw and one for bearing and
// distance, plus multiply and clamp states, with an extra slow-down state
// when a large heading error cuts the forward speed. Only one word is in flight:
// the next odometry word is taken in the cycle after the speed word is accepted.
// Within 0.05 m the block reports goal reached with zero speeds and disarms.
module go_to_goal_drive_controller_core #(
    parameter int CORDIC_STEPS = gtg_pkg::CordicStepsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [15:0] i_quat_x,
    input  logic signed [15:0] i_quat_y,
    input  logic signed [15:0] i_quat_z,
    input  logic signed [15:0] i_quat_w,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [14:0] o_linear_speed,
    output logic signed [17:0] o_turn_rate,
    output logic               o_goal_reached
);
    import gtg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_M1, S_M2, S_M3, S_YAW, S_YAW_W, S_BRG, S_BRG_W,
        S_M4, S_FIN, S_SLOW, S_OUT
    } t_state;

    t_state                 r_state;
    logic                   r_armed;
    logic signed [31:0]     r_goal_x, r_goal_y;
    logic signed [31:0]     r_px, r_py;
    logic signed [15:0]     r_qx, r_qy, r_qz, r_qw;
    logic signed [31:0]     r_p0, r_p1;
    logic signed [VecW-1:0] r_cx, r_cy;
    logic                   r_cstart;
    logic signed [17:0]     r_yaw, r_err;
    logic [33:0]            r_dist;
    logic [33:0]            r_v;
    logic signed [21:0]     r_w;
    logic                   r_out_valid;
    logic signed [14:0]     r_lin;
    logic signed [17:0]     r_turn;
    logic                   r_reached;

    logic                   w_cdone;
    logic signed [AngW-1:0] w_cang;
    logic signed [VecW-1:0] w_cmag;
    logic signed [17:0]     w_ang13;
    logic signed [17:0]     w_err_raw, w_err_wrap;
    logic [56:0]            w_dist_prod;
    logic [49:0]            w_slow_prod;

    gtg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cstart),
        .i_x     (r_cx),
        .i_y     (r_cy),
        .o_done  (w_cdone),
        .o_angle (w_cang),
        .o_mag   (w_cmag)
    );

    assign w_ang13    = 18'((w_cang + AngW'(1024)) >>> 11);
    assign w_err_raw  = w_ang13 - r_yaw;
    assign w_err_wrap = (w_err_raw > PiQ13) ? w_err_raw - TwoPiQ13 :
                        (w_err_raw < -PiQ13) ? w_err_raw + TwoPiQ13 : w_err_raw;
    assign w_dist_prod = 57'($unsigned(w_cmag)) * 57'(InvGainQ15) + 57'd16384;
    assign w_slow_prod = 50'(r_v) * 50'(SlowQ16) + 50'd32768;

    assign o_ready = (r_state == S_IDLE) && !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_armed     <= 1'b0;
            r_goal_x    <= '0;
            r_goal_y    <= '0;
            r_cstart    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cstart <= (r_state == S_YAW) || (r_state == S_BRG);
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CfgGoalX) begin
                    r_goal_x <= i_cfg_data;
                    r_armed  <= 1'b1;
                end else if (i_cfg_index == CfgGoalY) begin
                    r_goal_y <= i_cfg_data;
                    r_armed  <= 1'b1;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready && r_armed) begin
                        r_px <= i_pos_x;
                        r_py <= i_pos_y;
                        r_qx <= i_quat_x;
                        r_qy <= i_quat_y;
                        r_qz <= i_quat_z;
                        r_qw <= i_quat_w;
                        r_state <= S_M1;
                    end
                end
                S_M1: begin
                    r_p0 <= r_qw * r_qz;
                    r_p1 <= r_qx * r_qy;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_cy <= VecW'(r_p0) + VecW'(r_p1);
                    r_p0 <= r_qy * r_qy;
                    r_p1 <= r_qz * r_qz;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_cy <= r_cy <<< 1;
                    r_cx <= (VecW'(1) <<< 28) - ((VecW'(r_p0) + VecW'(r_p1)) <<< 1);
                    r_state <= S_YAW;
                end
                S_YAW: begin
                    r_state  <= S_YAW_W;
                end
                S_YAW_W: begin
                    if (w_cdone) begin
                        r_yaw <= w_ang13;
                        r_cx  <= VecW'(r_goal_x) - VecW'(r_px);
                        r_cy  <= VecW'(r_goal_y) - VecW'(r_py);
                        r_state <= S_BRG;
                    end
                end
                S_BRG: begin
                    r_state  <= S_BRG_W;
                end
                S_BRG_W: begin
                    if (w_cdone) begin
                        r_err  <= w_err_wrap;
                        r_dist <= 34'(w_dist_prod >> 15);
                        r_state <= S_M4;
                    end
                end
                S_M4: begin
                    r_v <= ((r_dist >> 1) > VmaxQ16) ? VmaxQ16 : (r_dist >> 1);
                    r_w <= 22'(r_err) * 22'sd12;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_w > WmaxQ16) begin
                        r_w <= WmaxQ16;
                    end else if (r_w < -WmaxQ16) begin
                        r_w <= -WmaxQ16;
                    end
                    if (r_err > ErrSlowQ13 || r_err < -ErrSlowQ13) begin
                        r_state <= S_SLOW;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_SLOW: begin
                    r_v <= 34'(w_slow_prod >> 16);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    if (r_dist < TolQ16) begin
                        r_lin     <= '0;
                        r_turn    <= '0;
                        r_reached <= 1'b1;
                        r_armed   <= 1'b0;
                    end else begin
                        r_lin     <= 15'(r_v);
                        r_turn    <= 18'(r_w);
                        r_reached <= 1'b0;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = r_out_valid;
    assign o_linear_speed = r_lin;
    assign o_turn_rate    = r_turn;
    assign o_goal_reached = r_reached;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_ready) else $error("ready while busy");
    a_reach_disarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) && r_reached && !$past(i_cfg_we) |-> !r_armed)
        else $error("goal reached but still armed");
    a_reach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_reached |-> r_lin == '0 && r_turn == '0)
        else $error("nonzero speed at goal");

endmodule

FILE: design/gtg_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Go-to-goal CORDIC vectoring unit
// Computes angle (Q24) and gain-scaled magnitude of a vector, one micro-rotation
// per cycle after an optional quadrant pre-rotation.
// ----------------------------------------------------------------------------
module gtg_cordic #(
    parameter int STEPS = gtg_pkg::CordicStepsDefault
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [gtg_pkg::VecW-1:0]     i_x,
    input  logic signed [gtg_pkg::VecW-1:0]     i_y,
    output logic                                o_done,
    output logic signed [gtg_pkg::AngW-1:0]     o_angle,
    output logic signed [gtg_pkg::VecW-1:0]     o_mag
);
    import gtg_pkg::*;

    localparam int CntW = $clog2(STEPS + 1);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [CntW-1:0]        r_cnt, n_cnt;
    logic signed [VecW-1:0] r_x, n_x, r_y, n_y;
    logic signed [AngW-1:0] r_z, n_z;
    logic signed [VecW-1:0] w_xs, w_ys;

    assign w_xs = r_x >>> r_cnt;
    assign w_ys = r_y >>> r_cnt;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        if (i_start) begin
            n_cnt = '0;
            n_z   = '0;
            if (i_x == '0 && i_y == '0) begin
                n_x = '0;
                n_y = '0;
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                if (i_x < 0) begin
                    if (i_y >= 0) begin
                        n_x = i_y;
                        n_y = -i_x;
                        n_z = HalfPiQ24;
                    end else begin
                        n_x = -i_y;
                        n_y = i_x;
                        n_z = -HalfPiQ24;
                    end
                end else begin
                    n_x = i_x;
                    n_y = i_y;
                end
            end
        end else if (r_busy) begin
            if (r_y > 0) begin
                n_x = r_x + w_ys;
                n_y = r_y - w_xs;
                n_z = r_z + atan_q24(5'(r_cnt));
            end else begin
                n_x = r_x - w_ys;
                n_y = r_y + w_xs;
                n_z = r_z - atan_q24(5'(r_cnt));
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CntW'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_done  = r_done;
    assign o_angle = r_z;
    assign o_mag   = r_x;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt < CntW'(STEPS)) else $error("step count overrun");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done || $past(i_start)) else $error("done held");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Go-to-goal drive controller testbench
// Drives odometry words through a directed table and then through random
// approach runs toward changing goals. An in-bench model predicts most speed
// commands, goal-reached rows expect zero speeds, and results are checked in
// order under random idling and stalls.
module tb;
    import gtg_pkg::*;

    localparam int ItemsPerRun = 25;
    localparam int RandomRuns  = 20;
    localparam int DrainCycles = 120;
    localparam logic [1:0] CfgSpareA = 2'd2;
    localparam logic [1:0] CfgSpareB = 2'd3;
    localparam longint AtanQ24[24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct packed {
        logic signed [14:0] lin;
        logic signed [17:0] turn;
        logic               reached;
    } speed_cmd_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } odom_t;

    typedef enum logic {RowWrite, RowSample} row_kind_t;
    typedef enum logic [1:0] {ChkModel, ChkNone, ChkReached} row_check_t;

    typedef struct {
        row_kind_t  kind;
        logic [1:0] idx;
        logic [31:0] data;
        odom_t      odom;
        row_check_t check;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [31:0] i_pos_x = '0;
    logic signed [31:0] i_pos_y = '0;
    logic signed [15:0] i_quat_x = '0;
    logic signed [15:0] i_quat_y = '0;
    logic signed [15:0] i_quat_z = '0;
    logic signed [15:0] i_quat_w = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [14:0] o_linear_speed;
    logic signed [17:0] o_turn_rate;
    logic o_goal_reached;

    longint goal_x = 0;
    longint goal_y = 0;
    bit armed = 1'b0;
    speed_cmd_t pending_cmds[$];
    int errors = 0;
    bit calm = 1'b0;
    bit squeeze = 1'b0;

    go_to_goal_drive_controller_core dut (.*);

    always #1 i_clk = ~i_clk;

    initial begin
        #1_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic longint vector_angle(input longint x, input longint y,
                                            output longint mag);
        longint z;
        longint t;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0) begin
            mag = 0;
            return 0;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = HalfPiQ24;
            end else begin
                x = -y;
                y = t;
                z = -HalfPiQ24;
            end
        end
        for (int i = 0; i < CordicStepsDefault && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys;
                y -= xs;
                z += AtanQ24[i];
            end else begin
                x -= ys;
                y += xs;
                z -= AtanQ24[i];
            end
        end
        mag = x;
        return z;
    endfunction

    function automatic void predict_command(input odom_t o, output bit has,
                                            output speed_cmd_t cmd);
        longint qx, qy, qz, qw, num, den, mag, yaw, brg, dist_q16, err, v, w, aerr;
        has = armed;
        cmd = '0;
        if (!armed)
            return;
        qx = o.qx;
        qy = o.qy;
        qz = o.qz;
        qw = o.qw;
        num = 2 * (qw * qz + qx * qy);
        den = (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz);
        yaw = (vector_angle(den, num, mag) + 1024) >>> 11;
        brg = (vector_angle(goal_x - longint'(o.px), goal_y - longint'(o.py), mag)
               + 1024) >>> 11;
        dist_q16 = (mag * InvGainQ15 + 16384) >>> 15;
        err = brg - yaw;
        while (err > PiQ13)
            err -= TwoPiQ13;
        while (err < -PiQ13)
            err += TwoPiQ13;
        if (dist_q16 < TolQ16) begin
            cmd.reached = 1'b1;
            armed = 1'b0;
            return;
        end
        v = dist_q16 >>> 1;
        if (v > VmaxQ16)
            v = VmaxQ16;
        aerr = (err < 0) ? -err : err;
        if (aerr > ErrSlowQ13)
            v = (v * SlowQ16 + 32768) >>> 16;
        w = err * 12;
        if (w > WmaxQ16)
            w = WmaxQ16;
        if (w < -WmaxQ16)
            w = -WmaxQ16;
        cmd.lin = v[14:0];
        cmd.turn = w[17:0];
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_goal(input logic [1:0] idx, input logic [31:0] data);
        i_valid <= 1'b0;
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CfgGoalX) begin
            goal_x = longint'(signed'(data));
            armed = 1'b1;
        end else if (idx == CfgGoalY) begin
            goal_y = longint'(signed'(data));
            armed = 1'b1;
        end
        @(posedge i_clk);
    endtask

    task automatic send_odom(input odom_t o, input row_check_t check);
        int gap;
        bit has;
        speed_cmd_t cmd;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pos_x <= o.px;
        i_pos_y <= o.py;
        i_quat_x <= o.qx;
        i_quat_y <= o.qy;
        i_quat_z <= o.qz;
        i_quat_w <= o.qw;
        do @(posedge i_clk); while (!o_ready);
        predict_command(o, has, cmd);
        if (check == ChkReached)
            pending_cmds.push_back(speed_cmd_t'{lin: '0, turn: '0, reached: 1'b1});
        else if (check == ChkModel && has)
            pending_cmds.push_back(cmd);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_quat();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 16'($signed($urandom_range(0, 32768)) - 16384);
        if (r < 8)
            return (r[0]) ? 16'sd16384 : -16'sd16384;
        return 16'($urandom);
    endfunction

    always @(posedge i_clk) begin
        static int stall_left = 0;
        static int r = 0;
        static bit squeeze_done = 1'b0;
        speed_cmd_t exp_cmd;
        if (o_valid && i_ready) begin
            if (pending_cmds.size() == 0) begin
                report("speed word with nothing expected");
            end else begin
                exp_cmd = pending_cmds.pop_front();
                if (o_linear_speed !== exp_cmd.lin)
                    report($sformatf("linear %0d, expected %0d",
                                     o_linear_speed, exp_cmd.lin));
                if (o_turn_rate !== exp_cmd.turn)
                    report($sformatf("turn %0d, expected %0d",
                                     o_turn_rate, exp_cmd.turn));
                if (o_goal_reached !== exp_cmd.reached)
                    report($sformatf("reached %0b, expected %0b",
                                     o_goal_reached, exp_cmd.reached));
            end
        end
        if (squeeze && !squeeze_done) begin
            stall_left = 600;
            squeeze_done = 1'b1;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                i_ready <= 1'b1;
            end else begin
                stall_left = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
                i_ready <= 1'b0;
            end
        end
    end

    row_t rows[] = '{
        '{RowSample, CfgGoalX, 32'h0, '{0, 0, 0, 0, 0, 16384}, ChkNone},
        '{RowWrite, CfgSpareA, 32'h5, '0, ChkNone},
        '{RowWrite, CfgSpareB, 32'h7, '0, ChkNone},
        '{RowSample, CfgGoalX, 32'h0, '{100, 100, 0, 0, 0, 16384}, ChkNone},
        '{RowWrite, CfgGoalX, 32'h0, '0, ChkNone},
        '{RowSample, CfgGoalX, 32'h0, '{0, 0, 0, 0, 0, 16384}, ChkReached},
        '{RowSample, CfgGoalX, 32'h0, '{0, 0, 0, 0, 0, 16384}, ChkNone},
        '{RowWrite, CfgGoalY, 32'h10000, '0, ChkNone},
        '{RowSample, CfgGoalX, 32'h0, '{0, 0, 0, 0, 0, 16384}, ChkModel},
        '{RowSample, CfgGoalX, 32'h0, '{0, 0, 0, 0, 0, 0}, ChkModel},
        '{RowSample, CfgGoalX, 32'h0, '{0, 0, -16384, -16384, -16384, -16384}, ChkModel},
        '{RowSample, CfgGoalX, 32'h0, '{0, 0, 16384, 16384, 16384, 16384}, ChkModel},
        '{RowSample, CfgGoalX, 32'h0, '{32'h80000000, 32'h7fffffff, 0, 0, 16384, 0},
          ChkModel},
        '{RowSample, CfgGoalX, 32'h0, '{3277, 65536, 0, 0, 0, 16384}, ChkModel},
        '{RowSample, CfgGoalX, 32'h0, '{3277, 65536, 0, 0, -16384, 0}, ChkModel},
        '{RowSample, CfgGoalX, 32'h0, '{0, 65536, 32'h8000, 32'h7fff, 32'h8000, 32'h7fff},
          ChkReached},
        '{RowWrite, CfgGoalX, 32'h7fffffff, '0, ChkNone},
        '{RowWrite, CfgGoalY, 32'h80000000, '0, ChkNone},
        '{RowSample, CfgGoalX, 32'h0, '{32'h80000000, 32'h7fffffff, 0, 0, 0, 16384},
          ChkModel},
        '{RowSample, CfgGoalX, 32'h0, '{32'h7fffffff, 32'h7fffffff, 100, -200, 300, 0},
          ChkModel},
        '{RowSample, CfgGoalX, 32'h0, '{32'h7fffffff, 32'h80000000, 0, 0, 0, 16384},
          ChkReached},
        '{RowWrite, CfgGoalX, 32'h80000000, '0, ChkNone},
        '{RowWrite, CfgGoalY, 32'h7fffffff, '0, ChkNone},
        '{RowSample, CfgGoalX, 32'h0, '{32'h80000000 + 5000, 32'h7fffffff, 0, 0, 0, 16384},
          ChkModel},
        '{RowSample, CfgGoalX, 32'h0, '{32'h80000000, 32'h7fffffff - 9000, 0, 0, 0, 16384},
          ChkModel},
        '{RowSample, CfgGoalX, 32'h0, '{32'h80000000, 32'h7fffffff, 0, 0, 0, 16384},
          ChkReached}
    };

    initial begin
        odom_t o;
        longint off_x;
        longint off_y;
        int pick;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].kind == RowWrite) begin
                drain();
                write_goal(rows[k].idx, rows[k].data);
            end else begin
                send_odom(rows[k].odom, rows[k].check);
            end
        end

        for (int run = 0; run < RandomRuns; run++) begin
            drain();
            calm <= (run % 5 == 4);
            squeeze <= (run == 3);
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                write_goal(CfgGoalX, 32'($signed($urandom_range(0, 2000000)) - 1000000));
                write_goal(CfgGoalY, 32'($signed($urandom_range(0, 2000000)) - 1000000));
            end else if (pick < 8) begin
                write_goal((pick[0]) ? CfgGoalX : CfgGoalY, $urandom);
            end else begin
                write_goal(CfgGoalX, (pick[0]) ? 32'h7fffffff : 32'h80000000);
                write_goal(CfgGoalY, (pick[0]) ? 32'h80000000 : 32'h7fffffff);
            end
            off_x = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            off_y = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            for (int n = 0; n < ItemsPerRun; n++) begin
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    o.px = $urandom;
                    o.py = $urandom;
                end else begin
                    o.px = 32'(goal_x - off_x + $signed($urandom_range(0, 64)) - 32);
                    o.py = 32'(goal_y - off_y + $signed($urandom_range(0, 64)) - 32);
                end
                o.qx = rand_quat();
                o.qy = rand_quat();
                o.qz = rand_quat();
                o.qw = rand_quat();
                send_odom(o, ChkModel);
                off_x = (off_x * int'($urandom_range(40, 85))) / 100;
                off_y = (off_y * int'($urandom_range(40, 85))) / 100;
                if (pick == 1 && armed) begin
                    drain();
                    write_goal((n[0]) ? CfgGoalX : CfgGoalY,
                               (n[0]) ? 32'(goal_x) : 32'(goal_y));
                end
            end
            squeeze <= 1'b0;
        end

        drain();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
